// ----- src/telemetry_frame_encoder_macros.svh -----
// Assertion macros for the telemetry frame encoder.
// Used by the top level; relies on signals named clk and rst in scope.
`ifndef TELEMETRY_FRAME_ENCODER_MACROS_SVH
`define TELEMETRY_FRAME_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define TFE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("telemetry frame encoder check failed");
`define TFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("telemetry frame encoder check failed");
`else
`define TFE_ASSERT_NOW(lbl, ante, cons)
`define TFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/tfe_pkg.sv -----
// Shared types, constants and the checksum function of the telemetry frame encoder.
// No dependencies.
package tfe_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] MARK_FLAG = 8'h7E;
  localparam logic [7:0] MARK_ESC  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam logic [7:0] CK_BASE   = 8'hFF;

  // Byte 0 goes on the line first; byte 7 is the checksum.
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // The sum of seven bytes fits in 11 bits; its high part is folded back in.
  function automatic logic [7:0] frame_checksum(input logic [7:0]  header_byte,
                                                input logic [15:0] value_id,
                                                input logic [31:0] value_word);
    logic [10:0] total;
    logic [10:0] folded;
    total = 11'(header_byte) + 11'(value_id[7:0]) + 11'(value_id[15:8])
          + 11'(value_word[7:0]) + 11'(value_word[15:8])
          + 11'(value_word[23:16]) + 11'(value_word[31:24]);
    folded = total + (total >> 8);
    return CK_BASE - folded[7:0];
  endfunction

endpackage

// ----- src/tfe_front.sv -----
// Front end: accepts payloads, computes the checksum and packs the frame.
// Depends on tfe_pkg; feeds the frame queue.
module tfe_front import tfe_pkg::*; (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    header_byte,
  input  logic [15:0]   value_id,
  input  logic [31:0]   value_word,
  input  queue_status_t q_stat,
  output logic          push,
  output frame_t        push_frame
);

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_frame[0] = header_byte;
    push_frame[1] = value_id[7:0];
    push_frame[2] = value_id[15:8];
    push_frame[3] = value_word[7:0];
    push_frame[4] = value_word[15:8];
    push_frame[5] = value_word[23:16];
    push_frame[6] = value_word[31:24];
    push_frame[7] = frame_checksum(header_byte, value_id, value_word);
  end

endmodule

// ----- src/tfe_queue.sv -----
// Short frame queue between the front end and the byte serializer.
// Depends on tfe_pkg for the frame and status types.
module tfe_queue import tfe_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_t        push_frame,
  input  logic          pop,
  output frame_t        head,
  output queue_status_t q_stat
);

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  frame_t             slots [Depth];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = (count == CNT_W'(Depth));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_frame;
    end
  end

endmodule

// ----- src/tfe_back.sv -----
// Back end: walks the head frame byte by byte, stuffs flag and escape bytes
// and holds each line byte in the output register. Depends on tfe_pkg.
module tfe_back import tfe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  frame_t        head,
  input  queue_status_t q_stat,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          last_byte,
  output logic          esc_pending
);

  localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(FRAME_BYTES - 1);

  logic [BYTE_IDX_W-1:0] idx;
  logic [BYTE_IDX_W-1:0] idx_next;
  logic                  esc_pending_next;
  logic                  out_valid_next;
  logic [7:0]            out_byte_next;
  logic                  last_byte_next;
  logic                  load;
  logic                  advance;
  logic [7:0]            cur;
  logic                  is_mark;

  assign load    = !out_valid || !out_stall;
  assign cur     = head[idx];
  assign is_mark = (cur == MARK_FLAG) || (cur == MARK_ESC);

  always_comb begin
    out_valid_next   = out_valid;
    out_byte_next    = out_byte;
    last_byte_next   = last_byte;
    esc_pending_next = esc_pending;
    advance          = 1'b0;
    if (load) begin
      out_valid_next = !q_stat.empty;
      if (!q_stat.empty) begin
        if (esc_pending) begin
          out_byte_next    = (cur == MARK_FLAG) ? ESC_FLAG : ESC_ESC;
          last_byte_next   = (idx == LAST_IDX);
          esc_pending_next = 1'b0;
          advance          = 1'b1;
        end else if (is_mark) begin
          out_byte_next    = MARK_ESC;
          last_byte_next   = 1'b0;
          esc_pending_next = 1'b1;
        end else begin
          out_byte_next  = cur;
          last_byte_next = (idx == LAST_IDX);
          advance        = 1'b1;
        end
      end
    end
  end

  // The frame leaves the queue together with its final line byte.
  assign pop      = advance && (idx == LAST_IDX);
  assign idx_next = !advance ? idx : ((idx == LAST_IDX) ? '0 : idx + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      esc_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      idx         <= idx_next;
      esc_pending <= esc_pending_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_byte  <= out_byte_next;
    last_byte <= last_byte_next;
  end

endmodule

// ----- src/telemetry_frame_encoder.sv -----
// Telemetry frame encoder, top level. Holds the front end, frame queue and
// serializer; depends on tfe_pkg and telemetry_frame_encoder_macros.svh.
//
// The input channel takes one payload request (header_byte, value_id,
// value_word) per cycle while the frame queue has room; in_stall rises only
// when the queue is full. The output channel gives 8 to 16 line bytes per request,
// low bytes first, checksum last, with 0x7E and 0x7D escaped as two bytes.
// last_byte marks the final byte of each frame.
// When the serializer is idle, an accepted payload is first written into the
// queue and its first byte is then loaded into the output register. A frame
// is 8 to 16 line bytes on the output, and frames follow each other with no
// gap, so the serializer's one byte per cycle, while the output is not
// stalled, sets the sustained rate; the queue lets the input run ahead.
// A stall on the output holds the current byte and freezes the serializer;
// the input keeps accepting until the queue is full.
// Reset empties the queue and drops any frame that is partly sent.
`include "telemetry_frame_encoder_macros.svh"

module telemetry_frame_encoder import tfe_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  header_byte,
  input  logic [15:0] value_id,
  input  logic [31:0] value_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  queue_status_t q_stat;
  frame_t        push_frame;
  frame_t        head;
  logic          push;
  logic          pop;
  logic          esc_pending;

  tfe_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .header_byte (header_byte),
    .value_id    (value_id),
    .value_word  (value_word),
    .q_stat      (q_stat),
    .push        (push),
    .push_frame  (push_frame)
  );

  tfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  tfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_byte   (last_byte),
    .esc_pending (esc_pending)
  );

  // An accepted payload is always waiting in the queue on the next cycle.
  `TFE_ASSERT_NEXT(a_push_lands, in_valid && !in_stall, !q_stat.empty)
  // A flag byte never reaches the line unescaped.
  `TFE_ASSERT_NOW(a_no_raw_flag, out_valid, out_byte != MARK_FLAG)
  // An escape byte is never the frame's last byte.
  `TFE_ASSERT_NOW(a_esc_not_last, out_valid && out_byte == MARK_ESC, !last_byte && esc_pending)
  // A taken escape byte is followed at once by its substitute.
  `TFE_ASSERT_NEXT(a_esc_follow, out_valid && !out_stall && out_byte == MARK_ESC, out_valid && (out_byte == ESC_FLAG || out_byte == ESC_ESC))

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for telemetry_frame_encoder: directed frames from a table,
// then biased random payloads, with random gaps on both channels.
// Depends only on the RTL (telemetry_frame_encoder and its package).
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] FLAG_SUB  = 8'h5E;
  localparam logic [7:0] ESC_SUB   = 8'h5D;
  localparam int RANDOM_FRAMES = 360;
  localparam int DIRECTED_ROWS = 13;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } line_byte_t;

  typedef struct packed {
    logic [7:0]  hdr;
    logic [15:0] id;
    logic [31:0] word;
    logic        ck_known;
    logic [7:0]  ck;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  header_byte = 8'h00;
  logic [15:0] value_id = 16'h0000;
  logic [31:0] value_word = 32'h0000_0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;

  line_byte_t expected_line[$];
  int mismatch_count = 0;
  int stall_left = 0;
  int quiet_left = 0;

  // Frames whose checksum can be read off at a glance carry it in the table.
  frame_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{8'h00, 16'h0000, 32'h0000_0000, 1'b1, 8'hFF},
    '{8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'h00},
    '{8'h7E, 16'h0000, 32'h0000_0000, 1'b1, 8'h81},
    '{8'h7D, 16'h0000, 32'h0000_0000, 1'b1, 8'h82},
    '{8'h81, 16'h0000, 32'h0000_0000, 1'b1, 8'h7E},
    '{8'h82, 16'h0000, 32'h0000_0000, 1'b1, 8'h7D},
    '{8'h80, 16'h0080, 32'h0000_0000, 1'b1, 8'hFE},
    '{8'h7E, 16'h7E7E, 32'h7E7E_7E7E, 1'b0, 8'h00},
    '{8'h7D, 16'h7D7D, 32'h7D7D_7D7D, 1'b0, 8'h00},
    '{8'h10, 16'h0800, 32'h1234_5678, 1'b0, 8'h00},
    '{8'h55, 16'hAAAA, 32'h5555_5555, 1'b0, 8'h00},
    '{8'hAA, 16'h5555, 32'hAAAA_AAAA, 1'b0, 8'h00},
    '{8'h10, 16'h7D7E, 32'h7E00_7DFF, 1'b0, 8'h00}
  };

  telemetry_frame_encoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .header_byte(header_byte),
    .value_id   (value_id),
    .value_word (value_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_byte  (last_byte)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sum of the seven payload bytes, high part folded back, subtracted from 0xFF.
  function automatic logic [7:0] payload_checksum(input logic [7:0] hdr,
                                                  input logic [15:0] id,
                                                  input logic [31:0] word);
    int unsigned total;
    total = hdr + id[7:0] + id[15:8] + word[7:0] + word[15:8] + word[23:16]
          + word[31:24];
    total = total + (total >> 8);
    return 8'hFF - total[7:0];
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got 0x%02h expected 0x%02h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_line_byte(input logic [7:0] b, input logic last);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      expected_line.push_back('{ESC_BYTE, 1'b0});
      expected_line.push_back('{(b == FLAG_BYTE) ? FLAG_SUB : ESC_SUB, last});
    end else begin
      expected_line.push_back('{b, last});
    end
  endtask

  task automatic send_payload(input logic [7:0] hdr, input logic [15:0] id,
                              input logic [31:0] word, input logic ck_known,
                              input logic [7:0] ck, input bit drain);
    int gap;
    logic [7:0] frame_ck;
    gap = pick_gap();
    if (drain || gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        @(posedge clk);
        while (expected_line.size() != 0) @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    header_byte <= hdr;
    value_id    <= id;
    value_word  <= word;
    do @(posedge clk); while (in_stall);
    frame_ck = ck_known ? ck : payload_checksum(hdr, id, word);
    push_line_byte(hdr, 1'b0);
    push_line_byte(id[7:0], 1'b0);
    push_line_byte(id[15:8], 1'b0);
    push_line_byte(word[7:0], 1'b0);
    push_line_byte(word[15:8], 1'b0);
    push_line_byte(word[23:16], 1'b0);
    push_line_byte(word[31:24], 1'b0);
    push_line_byte(frame_ck, 1'b1);
  endtask

  // Output back-pressure: quiet stretches alternate with stalls, mostly short.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (quiet_left > 0) begin
      out_stall  <= 1'b0;
      quiet_left <= quiet_left - 1;
    end else if ($urandom_range(0, 99) < 60) begin
      out_stall  <= 1'b0;
      quiet_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(0, 8);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    line_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_line.size() == 0) begin
        report_mismatch("line byte with no frame pending", out_byte, 8'h00);
      end else begin
        want = expected_line.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (last_byte !== want.last) begin
          report_mismatch("last_byte", {7'd0, last_byte}, {7'd0, want.last});
        end
      end
    end
  end

  initial begin
    logic [7:0]  hdr;
    logic [15:0] id;
    logic [31:0] word;
    logic [7:0]  target;
    bit drain;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_payload(directed_rows[r].hdr, directed_rows[r].id, directed_rows[r].word,
                   directed_rows[r].ck_known, directed_rows[r].ck, 1'b0);
    end

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      hdr  = pick_byte();
      id   = {pick_byte(), pick_byte()};
      word = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
      // Now and then steer the header so the checksum itself needs escaping.
      if ($urandom_range(0, 7) == 0) begin
        target = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
        for (int h = 0; h < 256; h++) begin
          if (payload_checksum(8'(h), id, word) == target) hdr = 8'(h);
        end
      end
      drain = (n == RANDOM_FRAMES / 3) || (n == 2 * RANDOM_FRAMES / 3)
            || ($urandom_range(0, 49) == 0);
      send_payload(hdr, id, word, 1'b0, 8'h00, drain);
    end
    in_valid <= 1'b0;

    while (expected_line.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_line.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout at %0t with %0d line bytes pending", $realtime, expected_line.size());
    $display("status: fail");
    $finish;
  end

endmodule
